// ===== hw/rtl/coab_pkg.sv =====
// Shared types, constants and helpers for the centred overlay alpha blender.
`default_nettype none
package coab_pkg;

  localparam int OVERLAY_PIXELS = 4096;
  localparam int MAX_BASE_SIDE  = 4096;

  localparam int          BASE_DIM_W  = 13;
  localparam int          OVL_DIM_W   = 7;
  localparam int          CFG_IDX_W   = 3;
  localparam int          CFG_DATA_W  = 13;
  localparam int          POS_W       = 15;
  localparam int          OVL_MAX_SIDE = 64;
  localparam int          OVL_SLOT_W  = 13;
  localparam logic [7:0]  FULL_ALPHA  = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_WIDTH     = 3'd0,
    CFG_BASE_HEIGHT    = 3'd1,
    CFG_OVERLAY_WIDTH  = 3'd2,
    CFG_OVERLAY_HEIGHT = 3'd3
  } cfg_idx_t;

  typedef enum logic {
    REQ_OVERLAY_LOAD = 1'b0,
    REQ_BASE_PIXEL   = 1'b1
  } req_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        last_of_frame;
  } out_item_t;

  // Exact floor(x / 255) for x below 65280, where the quotient fits in eight bits.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/coab_store.sv =====
// Overlay pixel store: one write port, one registered read port with enable.
`default_nettype none
module coab_store #(
  parameter int DEPTH = coab_pkg::OVERLAY_PIXELS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]        rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/centered_overlay_alpha_blend.sv =====
// Top level: centred ARGB8888 overlay blended onto a streamed base image.
// Throughput: one transaction per cycle while out_stall does not back up the pipeline; overlay loads produce no result.
// Stages: store read, per-channel products, divide by 255 into the output register.
// Reset (rst_n low, synchronous): dimensions return to 16, load index and raster
// position to zero, pipeline emptied; overlay store contents are not cleared.
`default_nettype none
module centered_overlay_alpha_blend #(
  parameter int OVERLAY_PIXELS = coab_pkg::OVERLAY_PIXELS,
  parameter int MAX_BASE_SIDE  = coab_pkg::MAX_BASE_SIDE
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire coab_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output coab_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [coab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [coab_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int BW = coab_pkg::BASE_DIM_W;
  localparam int OW = coab_pkg::OVL_DIM_W;
  localparam int PW = coab_pkg::POS_W;
  localparam int SW = coab_pkg::OVL_SLOT_W;
  localparam int AW = (OVERLAY_PIXELS > 1) ? $clog2(OVERLAY_PIXELS) : 1;
  localparam int EFF_SIDE = (MAX_BASE_SIDE < (2**BW - 1)) ? MAX_BASE_SIDE : (2**BW - 1);
  localparam int CW = (EFF_SIDE > 1) ? $clog2(EFF_SIDE) : 1;
  localparam int LOAD_LIM = (OVERLAY_PIXELS < (1 << (SW - 1))) ? OVERLAY_PIXELS
                                                               : (1 << (SW - 1));
  localparam int LW = (LOAD_LIM > 1) ? $clog2(LOAD_LIM) : 1;
  localparam logic [16:0] MAX_SIDE_C = 17'(MAX_BASE_SIDE);
  localparam logic [16:0] OVL_PIX_C  = 17'(OVERLAY_PIXELS);
  localparam logic [OW-1:0] OVL_MAX_C = OW'(coab_pkg::OVL_MAX_SIDE);

  // configuration
  logic [BW-1:0] bw_raw_r, bh_raw_r;
  logic [OW-1:0] ow_raw_r, oh_raw_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_raw_r <= BW'(16);
      bh_raw_r <= BW'(16);
      ow_raw_r <= OW'(16);
      oh_raw_r <= OW'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        coab_pkg::CFG_BASE_WIDTH:     bw_raw_r <= cfg_data[BW-1:0];
        coab_pkg::CFG_BASE_HEIGHT:    bh_raw_r <= cfg_data[BW-1:0];
        coab_pkg::CFG_OVERLAY_WIDTH:  ow_raw_r <= cfg_data[OW-1:0];
        coab_pkg::CFG_OVERLAY_HEIGHT: oh_raw_r <= cfg_data[OW-1:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions
  logic [BW-1:0] bw, bh;
  logic [OW-1:0] ow, oh;
  logic [SW-1:0] ovl_area;

  always_comb begin
    if (bw_raw_r == '0)                   bw = BW'(1);
    else if (17'(bw_raw_r) > MAX_SIDE_C)  bw = MAX_SIDE_C[BW-1:0];
    else                                  bw = bw_raw_r;
    if (bh_raw_r == '0)                   bh = BW'(1);
    else if (17'(bh_raw_r) > MAX_SIDE_C)  bh = MAX_SIDE_C[BW-1:0];
    else                                  bh = bh_raw_r;
    if (ow_raw_r == '0)                   ow = OW'(1);
    else if (ow_raw_r > OVL_MAX_C)        ow = OVL_MAX_C;
    else                                  ow = ow_raw_r;
    if (oh_raw_r == '0)                   oh = OW'(1);
    else if (oh_raw_r > OVL_MAX_C)        oh = OVL_MAX_C;
    else                                  oh = oh_raw_r;
    ovl_area = SW'(ow) * SW'(oh);
  end

  // handshake and stage enables
  logic s1_v_r, s2_v_r, out_v_r;
  logic en_out, en2, en1;
  logic in_acc, acc_base, acc_load;

  assign en_out   = !out_v_r || !out_stall;
  assign en2      = !s2_v_r || en_out;
  assign en1      = !s1_v_r || en2;
  assign in_stall = !en1;
  assign in_acc   = in_valid && en1;
  assign acc_base = in_acc && (in_data.req_type == coab_pkg::REQ_BASE_PIXEL);
  assign acc_load = in_acc && (in_data.req_type == coab_pkg::REQ_OVERLAY_LOAD);

  // overlay load index
  logic [LW-1:0] load_idx_r, load_idx_nxt;
  logic [16:0]   load_inc;

  always_comb begin
    load_inc = 17'(load_idx_r) + 17'd1;
    if (load_inc >= 17'(ovl_area) || load_inc >= OVL_PIX_C) load_idx_nxt = '0;
    else                                                   load_idx_nxt = load_inc[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        load_idx_r <= '0;
    else if (acc_load) load_idx_r <= load_idx_nxt;
  end

  // raster position and overlay coverage
  logic [CW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic signed [PW-1:0] dx, dy, hx, hy, ox, oy;
  logic [PW-1:0] dx_abs, dy_abs;
  logic last_col, last_row, covered, hit;
  logic [SW-1:0] slot;
  logic [16:0] slot_rd;

  always_comb begin
    dx = $signed(PW'(bw)) - $signed(PW'(ow));
    dy = $signed(PW'(bh)) - $signed(PW'(oh));
    dx_abs = dx[PW-1] ? PW'(-dx) : PW'(dx);
    dy_abs = dy[PW-1] ? PW'(-dy) : PW'(dy);
    hx = dx[PW-1] ? -$signed(dx_abs >> 1) : $signed(dx_abs >> 1);
    hy = dy[PW-1] ? -$signed(dy_abs >> 1) : $signed(dy_abs >> 1);
    ox = $signed(PW'(col_r)) - hx;
    oy = $signed(PW'(row_r)) - hy;
    covered = !ox[PW-1] && !oy[PW-1] && (ox < $signed(PW'(ow))) && (oy < $signed(PW'(oh)));
    slot = SW'(oy[OW-1:0]) * SW'(ow) + SW'(ox[OW-1:0]);
    slot_rd = 17'(slot);
    hit = covered && (slot_rd < OVL_PIX_C);
    last_col = (14'(col_r) + 14'd1) >= 14'(bw);
    last_row = (14'(row_r) + 14'd1) >= 14'(bh);
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : CW'(row_r + 1'b1);
    end else begin
      col_nxt = CW'(col_r + 1'b1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc_base) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // overlay store
  logic [31:0] ovl_pix;

  coab_store #(
    .DEPTH (OVERLAY_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (acc_load),
    .wr_addr (AW'(load_idx_r)),
    .wr_data (in_data.pixel),
    .rd_en   (acc_base),
    .rd_addr (slot_rd[AW-1:0]),
    .rd_data (ovl_pix)
  );

  // stage 1: base pixel alongside store read
  logic [31:0] s1_pix_r;
  logic        s1_hit_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)   s1_v_r <= 1'b0;
    else if (en1) s1_v_r <= acc_base;
  end

  always_ff @(posedge clk) begin
    if (acc_base) begin
      s1_pix_r  <= in_data.pixel;
      s1_hit_r  <= hit;
      s1_last_r <= last_col && last_row;
    end
  end

  // stage 2: per-channel weighted sums
  logic [15:0] sum [3];
  logic [7:0]  a1, a2, na2, alpha_max;

  always_comb begin
    a1  = s1_pix_r[31:24];
    a2  = ovl_pix[31:24];
    na2 = coab_pkg::FULL_ALPHA - a2;
    alpha_max = (a2 > a1) ? a2 : a1;
    for (int c = 0; c < 3; c++) begin
      sum[c] = 16'(ovl_pix[8*c +: 8]) * 16'(a2) + 16'(s1_pix_r[8*c +: 8]) * 16'(na2);
    end
  end

  logic [15:0] s2_sum_r [3];
  logic [31:0] s2_pix_r;
  logic [7:0]  s2_alpha_r;
  logic        s2_hit_r, s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n)   s2_v_r <= 1'b0;
    else if (en2) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_v_r) begin
      s2_sum_r   <= sum;
      s2_pix_r   <= s1_pix_r;
      s2_alpha_r <= alpha_max;
      s2_hit_r   <= s1_hit_r;
      s2_last_r  <= s1_last_r;
    end
  end

  // output stage: divide by 255 where the overlay hits, else pass the base pixel through
  coab_pkg::out_item_t out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt.last_of_frame = s2_last_r;
    if (s2_hit_r) begin
      out_data_nxt.pixel_out = {s2_alpha_r,
                                coab_pkg::div255(s2_sum_r[2]),
                                coab_pkg::div255(s2_sum_r[1]),
                                coab_pkg::div255(s2_sum_r[0])};
    end else begin
      out_data_nxt.pixel_out = s2_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      out_v_r <= 1'b0;
    else if (en_out) out_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_v_r) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_v_r))
    else $error("input stalled with a free pipeline stage");

  a_load_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc_load) |-> (17'(load_idx_r) < OVL_PIX_C))
    else $error("overlay load index beyond store");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_base && last_col && last_row) |=> (col_r == '0 && row_r == '0))
    else $error("raster position not cleared after last pixel of frame");

  a_last_tracks_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (en1 && acc_base) |=> (s1_v_r && s1_last_r == $past(last_col && last_row)))
    else $error("end-of-frame flag lost entering pipeline");

endmodule
`default_nettype wire

// ===== tb/sv/tb_centered_overlay_alpha_blend.sv =====
// Self-checking testbench for the centred overlay alpha blender: directed table, then random frames.
`default_nettype none
module tb_centered_overlay_alpha_blend;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT     = 3;
  localparam int SETTLE       = PIPE_LAT + 2;
  localparam int ITEM_TARGET  = 1350;
  localparam logic [coab_pkg::CFG_IDX_W-1:0] CFG_NO_REG_FIRST = 3'd4;
  localparam logic [coab_pkg::CFG_IDX_W-1:0] CFG_NO_REG_LAST  = 3'd7;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_BASE
  } row_kind_e;

  typedef struct packed {
    row_kind_e                          kind;
    logic [coab_pkg::CFG_IDX_W-1:0]     idx;
    logic [31:0]                        value;
    logic                               typed;
    logic [31:0]                        exp_pix;
    logic                               exp_last;
  } dir_row_t;

  localparam int N_DIR = 35;

  dir_row_t dir_rows [N_DIR] = '{
    '{ROW_CFG,  coab_pkg::CFG_BASE_WIDTH,     32'd3,        1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  coab_pkg::CFG_BASE_HEIGHT,    32'd2,        1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  coab_pkg::CFG_OVERLAY_WIDTH,  32'd1,        1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  coab_pkg::CFG_OVERLAY_HEIGHT, 32'd1,        1'b0, 32'h0,        1'b0},
    '{ROW_LOAD, coab_pkg::CFG_BASE_WIDTH,     32'hFF123456, 1'b0, 32'h0,        1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h00ABCDEF, 1'b1, 32'hFF123456, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h00000000, 1'b1, 32'h00000000, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h80000000, 1'b1, 32'h80000000, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h55AA55AA, 1'b1, 32'h55AA55AA, 1'b1},
    '{ROW_LOAD, coab_pkg::CFG_BASE_WIDTH,     32'h00FFFFFF, 1'b0, 32'h0,        1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h12345678, 1'b1, 32'h12345678, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'hA5C3E1F0, 1'b1, 32'hA5C3E1F0, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h0F0F0F0F, 1'b1, 32'h0F0F0F0F, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h00000000, 1'b1, 32'h00000000, 1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h01020304, 1'b1, 32'h01020304, 1'b1},
    '{ROW_LOAD, coab_pkg::CFG_BASE_WIDTH,     32'h80FF00FF, 1'b0, 32'h0,        1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h11223344, 1'b0, 32'h0,        1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h00FF00FF, 1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  CFG_NO_REG_FIRST,             32'h1FFF,     1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  CFG_NO_REG_LAST,              32'h0000,     1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  coab_pkg::CFG_BASE_WIDTH,     32'd0,        1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  coab_pkg::CFG_BASE_HEIGHT,    32'd0,        1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  coab_pkg::CFG_OVERLAY_WIDTH,  32'd0,        1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  coab_pkg::CFG_OVERLAY_HEIGHT, 32'd0,        1'b0, 32'h0,        1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'hDEADBEEF, 1'b0, 32'h0,        1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h00000000, 1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  coab_pkg::CFG_OVERLAY_WIDTH,  32'h1F83,     1'b0, 32'h0,        1'b0},
    '{ROW_CFG,  coab_pkg::CFG_OVERLAY_HEIGHT, 32'd1,        1'b0, 32'h0,        1'b0},
    '{ROW_LOAD, coab_pkg::CFG_BASE_WIDTH,     32'h7F000000, 1'b0, 32'h0,        1'b0},
    '{ROW_LOAD, coab_pkg::CFG_BASE_WIDTH,     32'hFF00FF00, 1'b0, 32'h0,        1'b0},
    '{ROW_LOAD, coab_pkg::CFG_BASE_WIDTH,     32'hFF0000FF, 1'b0, 32'h0,        1'b0},
    '{ROW_BASE, coab_pkg::CFG_BASE_WIDTH,     32'h00000000, 1'b1, 32'hFF00FF00, 1'b1}
  };

  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  coab_pkg::in_item_t                  in_data   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  coab_pkg::out_item_t                 out_data;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [coab_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [coab_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

  centered_overlay_alpha_blend dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // blender state as the testbench sees it
  logic [coab_pkg::BASE_DIM_W-1:0] dim_bw = 13'd16;
  logic [coab_pkg::BASE_DIM_W-1:0] dim_bh = 13'd16;
  logic [coab_pkg::OVL_DIM_W-1:0]  dim_ow = 7'd16;
  logic [coab_pkg::OVL_DIM_W-1:0]  dim_oh = 7'd16;
  logic [31:0]                     ovl_mem [coab_pkg::OVERLAY_PIXELS];
  bit                              ovl_written [coab_pkg::OVERLAY_PIXELS];
  int                              load_slot  = 0;
  int                              raster_col = 0;
  int                              raster_row = 0;

  coab_pkg::out_item_t pending_blends [$];

  bit sender_busy = 1'b1;
  bit stall_busy  = 1'b1;
  int stall_left  = 0;
  int errors      = 0;
  int n_loads     = 0;
  int n_bases     = 0;
  int n_settings  = 0;
  int n_compared  = 0;
  int n_frame_ends = 0;

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 32'h00000000;
      1: return 32'hFFFFFFFF;
      2: return {8'h00, 24'($urandom)};
      3: return {8'hFF, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic predict_blend(input coab_pkg::in_item_t it, output coab_pkg::out_item_t exp,
                               output bit has);
    int bw, bh, ow, oh, ox, oy, slot, a1, a2, c1, c2, full_a;
    logic [31:0] ovl, res;
    bw = clamp_dim(dim_bw, coab_pkg::MAX_BASE_SIDE);
    bh = clamp_dim(dim_bh, coab_pkg::MAX_BASE_SIDE);
    ow = clamp_dim(dim_ow, coab_pkg::OVL_MAX_SIDE);
    oh = clamp_dim(dim_oh, coab_pkg::OVL_MAX_SIDE);
    full_a = coab_pkg::FULL_ALPHA;
    exp = '0;
    has = 1'b0;
    if (it.req_type == coab_pkg::REQ_OVERLAY_LOAD) begin
      if (load_slot < coab_pkg::OVERLAY_PIXELS) begin
        ovl_mem[load_slot] = it.pixel;
        ovl_written[load_slot] = 1'b1;
      end
      load_slot++;
      if (load_slot >= ow * oh || load_slot >= coab_pkg::OVERLAY_PIXELS) load_slot = 0;
      n_loads++;
    end else begin
      ox = raster_col - (bw - ow) / 2;
      oy = raster_row - (bh - oh) / 2;
      res = it.pixel;
      if (ox >= 0 && oy >= 0 && ox < ow && oy < oh) begin
        slot = oy * ow + ox;
        if (slot < coab_pkg::OVERLAY_PIXELS) begin
          ovl = ovl_mem[slot];
          a1 = it.pixel[31:24];
          a2 = ovl[31:24];
          for (int ch = 0; ch < 3; ch++) begin
            c1 = it.pixel[8*ch +: 8];
            c2 = ovl[8*ch +: 8];
            res[8*ch +: 8] = 8'((c2 * a2 + c1 * (full_a - a2)) / full_a);
          end
          res[31:24] = 8'((a2 > a1) ? a2 : a1);
        end
      end
      exp.pixel_out = res;
      exp.last_of_frame = (raster_col + 1 >= bw) && (raster_row + 1 >= bh);
      if (raster_col + 1 >= bw) begin
        raster_col = 0;
        raster_row = (raster_row + 1 >= bh) ? 0 : raster_row + 1;
      end else begin
        raster_col++;
      end
      has = 1'b1;
      n_bases++;
    end
  endtask

  task automatic send_item(input coab_pkg::req_t req, input logic [31:0] pix, input bit typed,
                           input coab_pkg::out_item_t typed_exp);
    coab_pkg::in_item_t  it;
    coab_pkg::out_item_t exp;
    bit                  has;
    int                  gap;
    it.req_type = req;
    it.pixel = pix;
    gap = sender_busy ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_blend(it, exp, has);
    if (has) pending_blends.push_back(typed ? typed_exp : exp);
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [coab_pkg::CFG_IDX_W-1:0] idx,
                           input logic [coab_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      coab_pkg::CFG_BASE_WIDTH:     dim_bw = data[coab_pkg::BASE_DIM_W-1:0];
      coab_pkg::CFG_BASE_HEIGHT:    dim_bh = data[coab_pkg::BASE_DIM_W-1:0];
      coab_pkg::CFG_OVERLAY_WIDTH:  dim_ow = data[coab_pkg::OVL_DIM_W-1:0];
      coab_pkg::CFG_OVERLAY_HEIGHT: dim_oh = data[coab_pkg::OVL_DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // check each result transaction against the oldest prediction
  always @(posedge clk) begin
    coab_pkg::out_item_t e;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_blends.size() == 0) begin
        $display("%0t: unexpected result %08h last %0b", $time, out_data.pixel_out,
                 out_data.last_of_frame);
        errors++;
      end else begin
        e = pending_blends.pop_front();
        n_compared++;
        if (out_data.last_of_frame) n_frame_ends++;
        if (out_data.pixel_out !== e.pixel_out) begin
          $display("%0t: pixel_out expected %08h got %08h", $time, e.pixel_out,
                   out_data.pixel_out);
          errors++;
        end
        if (out_data.last_of_frame !== e.last_of_frame) begin
          $display("%0t: last_of_frame expected %0b got %0b", $time, e.last_of_frame,
                   out_data.last_of_frame);
          errors++;
        end
      end
      stall_left = stall_busy ? $urandom_range(0, 8) : 0;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int bw_raw, bh_raw, ow_raw, oh_raw, area, n_px;
    bit ready;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain_pipeline();
        write_reg(dir_rows[r].idx, dir_rows[r].value[coab_pkg::CFG_DATA_W-1:0]);
      end else begin
        send_item(dir_rows[r].kind == ROW_BASE ? coab_pkg::REQ_BASE_PIXEL
                                               : coab_pkg::REQ_OVERLAY_LOAD,
                  dir_rows[r].value, dir_rows[r].typed,
                  '{pixel_out: dir_rows[r].exp_pix, last_of_frame: dir_rows[r].exp_last});
      end
    end
    n_settings = 3;

    while (n_loads + n_bases < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 2))
            0: bw_raw = 0;
            1: bw_raw = coab_pkg::MAX_BASE_SIDE;
            default: bw_raw = 8191;
          endcase
          bh_raw = $urandom_range(0, 4);
        end
        1: begin
          bw_raw = $urandom_range(0, 8191);
          bh_raw = $urandom_range(0, 8191);
        end
        2: begin
          bw_raw = $urandom_range(1, 3);
          bh_raw = $urandom_range(1, 3);
        end
        default: begin
          bw_raw = $urandom_range(1, 10);
          bh_raw = $urandom_range(1, 8);
        end
      endcase
      case ($urandom_range(0, 9))
        0: begin
          ow_raw = 0;
          oh_raw = $urandom_range(0, 3);
        end
        1: begin
          ow_raw = $urandom_range(0, 1) ? 127 : coab_pkg::OVL_MAX_SIDE;
          oh_raw = 1;
        end
        2: begin
          ow_raw = 1;
          oh_raw = $urandom_range(65, 127);
        end
        default: begin
          ow_raw = $urandom_range(1, 6);
          oh_raw = $urandom_range(1, 6);
        end
      endcase

      drain_pipeline();
      write_reg(coab_pkg::CFG_BASE_WIDTH, 13'(bw_raw));
      write_reg(coab_pkg::CFG_BASE_HEIGHT, 13'(bh_raw));
      write_reg(coab_pkg::CFG_OVERLAY_WIDTH, {6'($urandom), 7'(ow_raw)});
      write_reg(coab_pkg::CFG_OVERLAY_HEIGHT, {6'($urandom), 7'(oh_raw)});
      if ($urandom_range(0, 3) == 0)
        write_reg(3'($urandom_range(CFG_NO_REG_FIRST, CFG_NO_REG_LAST)), 13'($urandom));
      n_settings++;
      sender_busy = $urandom_range(0, 3) != 0;
      stall_busy = $urandom_range(0, 3) != 0;

      // reload the overlay whenever part of it has never been written, and also at random
      area = clamp_dim(ow_raw, coab_pkg::OVL_MAX_SIDE) * clamp_dim(oh_raw, coab_pkg::OVL_MAX_SIDE);
      ready = 1'b1;
      for (int s = 0; s < area; s++) if (!ovl_written[s]) ready = 1'b0;
      if (!ready || $urandom_range(0, 3) == 0) begin
        while (load_slot != 0)
          send_item(coab_pkg::REQ_OVERLAY_LOAD, rand_pixel(), 1'b0, '0);
        repeat (area) send_item(coab_pkg::REQ_OVERLAY_LOAD, rand_pixel(), 1'b0, '0);
      end

      n_px = clamp_dim(bw_raw, coab_pkg::MAX_BASE_SIDE) * clamp_dim(bh_raw, coab_pkg::MAX_BASE_SIDE)
             * $urandom_range(1, 2);
      if (n_px > 60) n_px = $urandom_range(20, 60);
      n_px += $urandom_range(0, 3);
      repeat (n_px) begin
        if ($urandom_range(0, 11) == 0)
          send_item(coab_pkg::REQ_OVERLAY_LOAD, rand_pixel(), 1'b0, '0);
        send_item(coab_pkg::REQ_BASE_PIXEL, rand_pixel(), 1'b0, '0);
      end
    end

    drain_pipeline();
    $display("sent %0d transactions: %0d overlay loads, %0d base pixels, %0d register settings",
             n_loads + n_bases, n_loads, n_bases, n_settings);
    $display("compared %0d blended pixels across %0d frame ends", n_compared, n_frame_ends);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
